/* src/fqse_pkg.sv */
// Shared types and constants for the FASTQ sequence extractor.
package fqse_pkg;

   localparam int MAX_READ_LEN = 65536;
   localparam int LEN_W        = $clog2(MAX_READ_LEN + 1);

   localparam logic [7:0] CHAR_AT   = 8'h40;
   localparam logic [7:0] CHAR_PLUS = 8'h2B;
   localparam logic [7:0] CHAR_NL   = 8'h0A;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_HEADER = 3'd1,
      PH_SEQ    = 3'd2,
      PH_PLUS   = 3'd3,
      PH_PLUSNL = 3'd4,
      PH_QUAL   = 3'd5,
      PH_QUALNL = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ERR_NONE  = 3'd0,
      ERR_AT    = 3'd1,
      ERR_PLUS  = 3'd2,
      ERR_LONG  = 3'd3,
      ERR_TRUNC = 3'd4
   } err_type;

   // One result transaction as it leaves the parser.
   typedef struct packed {
      logic       produce;
      logic [7:0] out_byte;
      logic       has_byte;
      err_type    error_code;
      logic       stream_end;
   } result_type;

endpackage

/* src/fqse_parse.sv */
// Record parser: phase, length counter and sticky error for one byte per step.
module fqse_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [7:0]          in_byte,
   input  logic                last_byte,
   output fqse_pkg::result_type result
);
   import fqse_pkg::*;

   phase_type        phase_ff, phase_in, phase_nx;
   logic [LEN_W-1:0] len_ff, len_in, len_nx, len_dec;
   err_type          err_ff, err_in, err_raise, err_after;
   logic             emit;

   assign len_dec = (len_ff != '0) ? len_ff - LEN_W'(1) : len_ff;

   // Next phase and length for one byte; an error leaves both unchanged.
   always_comb begin
      phase_nx = phase_ff;
      len_nx   = len_ff;
      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte == CHAR_AT) phase_nx = PH_HEADER;
            end
            PH_HEADER: begin
               if (in_byte == CHAR_NL) begin
                  phase_nx = PH_SEQ;
                  len_nx   = '0;
               end
            end
            PH_SEQ: begin
               if (in_byte == CHAR_NL)                    phase_nx = PH_PLUS;
               else if (len_ff < LEN_W'(MAX_READ_LEN))    len_nx   = len_ff + LEN_W'(1);
            end
            PH_PLUS: begin
               if (in_byte == CHAR_PLUS) phase_nx = PH_PLUSNL;
            end
            PH_PLUSNL: begin
               if (in_byte == CHAR_NL) begin
                  if (len_ff == '0) phase_nx = PH_QUALNL;
                  else              phase_nx = PH_QUAL;
               end
            end
            PH_QUAL: begin
               len_nx = len_dec;
               if (len_dec == '0) phase_nx = PH_QUALNL;
            end
            default: begin
               phase_nx = PH_START;
               len_nx   = '0;
            end
         endcase
      end
   end

   // Per-byte outputs: extracted byte and newly raised error.
   always_comb begin
      err_raise = ERR_NONE;
      emit      = 1'b0;
      if (err_ff == ERR_NONE) begin
         unique case (phase_ff)
            PH_START: begin
               if (in_byte != CHAR_AT) err_raise = ERR_AT;
            end
            PH_SEQ: begin
               if (in_byte == CHAR_NL || len_ff < LEN_W'(MAX_READ_LEN)) emit = 1'b1;
               else                                                      err_raise = ERR_LONG;
            end
            PH_PLUS: begin
               if (in_byte != CHAR_PLUS) err_raise = ERR_PLUS;
            end
            PH_PLUSNL: begin
               if (in_byte != CHAR_NL) err_raise = ERR_PLUS;
            end
            default: ;
         endcase
         if (err_raise == ERR_NONE && last_byte && phase_nx != PH_START)
            err_raise = ERR_TRUNC;
      end
   end

   assign err_after = (err_raise != ERR_NONE) ? err_raise : err_ff;

   // Next state: end of file returns everything to its reset value.
   always_comb begin
      if (last_byte) begin
         phase_in = PH_START;
         len_in   = '0;
         err_in   = ERR_NONE;
      end else begin
         phase_in = phase_nx;
         len_in   = len_nx;
         err_in   = err_after;
      end
   end

   // Result for this byte.
   always_comb begin
      result.produce    = emit || (err_raise != ERR_NONE) || last_byte;
      result.out_byte   = emit ? in_byte : 8'h00;
      result.has_byte   = emit;
      result.error_code = err_after;
      result.stream_end = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         len_ff   <= '0;
         err_ff   <= ERR_NONE;
      end else if (step_en) begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         err_ff   <= err_in;
      end
   end

endmodule

/* src/fqse_out.sv */
// Result register toward the output stream.
module fqse_out (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  fqse_pkg::result_type result,
   output logic                 can_load,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);
   import fqse_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= result;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'b0, data_ff.error_code, data_ff.out_byte};
   assign rsp_tuser  = data_ff.has_byte;
   assign rsp_tlast  = data_ff.stream_end;

endmodule

/* src/fastq_sequence_extractor.sv */
// Top level of the FASTQ sequence extractor: input register, parser, result register.
//
// Takes a FASTQ file one byte per transaction and returns each record's
// sequence line including its newline; header and quality lines are dropped.
// One byte is taken every clock cycle when the output keeps up; an accepted
// byte waits in the input register, and its result is loaded into the
// result register once that register has room (input register, then result
// register). Bytes that give no result still pass through the parser at
// one per cycle. A result transaction is also returned when an
// error is first latched and for the byte marked tlast, which closes the file
// and returns the parser to its reset state so another file may follow. Errors
// are sticky until end of file: 1 missing '@', 2 bad '+' line, 3 read longer
// than MAX_READ_LEN, 4 record cut off by end of file. No clearing pass is
// needed after reset.
module fastq_sequence_extractor (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
   output logic        rsp_tuser,   // has_byte
   output logic        rsp_tlast    // stream_end
);
   import fqse_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       step_en, can_load;
   result_type result;

   // A held byte moves on when it makes no result or the result register has room.
   assign step_en     = in_valid_ff && (!result.produce || can_load);
   assign req_tready  = !in_valid_ff || step_en;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !step_en);

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   fqse_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_en),
      .in_byte   (in_byte_ff),
      .last_byte (in_last_ff),
      .result    (result)
   );

   fqse_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (step_en && result.produce),
      .result     (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* src/fqse_checker.sv */
// Port-level checks for the FASTQ sequence extractor and their binding.
module fqse_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import fqse_pkg::*;

   // Stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Without an extracted byte the byte field is zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[7:0] == 8'h00)
      else $error("byte field set without has_byte");

   // An extracted byte carries an error only on the final byte (truncation).
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && !rsp_tlast |-> rsp_tdata[10:8] == ERR_NONE)
      else $error("byte extracted while in error");

   // A transaction with no byte and no end of file must report an error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && !rsp_tlast |-> rsp_tdata[10:8] != ERR_NONE)
      else $error("empty result without error");

   // Error code stays within its defined range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[10:8] <= ERR_TRUNC)
      else $error("error code out of range");

endmodule

bind fastq_sequence_extractor fqse_checker u_fqse_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/sv/tb_fastq_sequence_extractor.sv */
// Self-checking testbench for the FASTQ sequence extractor: byte-stream driver, result monitor, parser model.
module tb_fastq_sequence_extractor;
   timeunit 1ns;
   timeprecision 1ps;

   import fqse_pkg::*;

   // Run aborts after this many cycles. Most of a correct run goes to the
   // phases with heavy idling.
   localparam int CYCLE_LIMIT = 100_000;
   // A byte passes the input register, then the result register, before its result leaves.
   localparam int DRAIN_CYCLES = 8;
   // Mismatches beyond this count are tallied but not printed.
   localparam int REPORT_MAX = 10;
   // Random bytes queued in each idling phase.
   localparam int BYTES_PER_PHASE = 300;

   // Ways a generated record can be damaged.
   typedef enum int {
      FLAW_NONE,
      FLAW_NO_AT,        // record opens with something other than '@'
      FLAW_PLUS_CHAR,    // separator line does not start with '+'
      FLAW_PLUS_NL,      // '+' is not followed directly by a newline
      FLAW_CUT           // file ends inside the record
   } flaw_type;

   // One byte of the input stream, with its end-of-file mark.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } file_byte_type;

   // One result transaction as the parser should return it.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      err_type    error_code;
      logic       stream_end;
   } extract_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] in_byte
   logic        req_tlast = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] out_byte, [10:8] error_code, rest zero
   logic        rsp_tuser;           // has_byte
   logic        rsp_tlast;           // stream_end

   fastq_sequence_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5ns clock = ~clock;

   // ------------------------------------------------------------------
   // Stimulus store and handshake bookkeeping
   // ------------------------------------------------------------------
   file_byte_type    pending_bytes[$];   // bytes waiting for the driver
   logic [7:0]       file_buf[$];        // file under construction
   extract_beat_type expected_beats[$];  // results still owed by the block
   file_byte_type    drive_item;
   extract_beat_type want;

   int   items_queued = 0;      // bytes handed to the driver so far
   int   items_taken = 0;       // bytes the block has accepted
   int   fail_count = 0;
   int   cycle_count = 0;
   int   sender_idle_pct = 0;   // chance per cycle that the sender holds off
   int   rsp_stall_pct = 0;     // chance per cycle that the receiver stalls
   logic req_taken = 1'b0;      // input transaction completed at last rising edge

   // ------------------------------------------------------------------
   // Parser model: state copy and per-byte prediction
   // ------------------------------------------------------------------
   phase_type        parse_phase = PH_START;
   logic [LEN_W-1:0] seq_count = '0;      // read length, then quality bytes left
   err_type          err_latch = ERR_NONE;

   // Consume one accepted byte and queue the result it causes, if any.
   function automatic void advance_parser(input logic [7:0] b, input logic last);
      extract_beat_type beat;
      logic             emit;
      logic             raised;
      err_type          err;
      beat   = '0;
      emit   = 1'b0;
      raised = 1'b0;
      err    = ERR_NONE;
      // Once an error is latched the rest of the file is just swallowed.
      if (err_latch == ERR_NONE) begin
         case (parse_phase)
            PH_START: begin
               if (b == CHAR_AT) parse_phase = PH_HEADER;
               else err = ERR_AT;
            end
            PH_HEADER: begin
               if (b == CHAR_NL) begin
                  parse_phase = PH_SEQ;
                  seq_count   = '0;
               end
            end
            PH_SEQ: begin
               // The sequence newline is passed on too; an over-long read
               // stops before the offending byte is copied.
               if (b == CHAR_NL) begin
                  emit        = 1'b1;
                  parse_phase = PH_PLUS;
               end else if (seq_count >= MAX_READ_LEN) begin
                  err = ERR_LONG;
               end else begin
                  emit      = 1'b1;
                  seq_count = seq_count + 1'b1;
               end
            end
            PH_PLUS: begin
               if (b == CHAR_PLUS) parse_phase = PH_PLUSNL;
               else err = ERR_PLUS;
            end
            PH_PLUSNL: begin
               if (b != CHAR_NL) err = ERR_PLUS;
               else parse_phase = (seq_count == 0) ? PH_QUALNL : PH_QUAL;
            end
            PH_QUAL: begin
               if (seq_count != 0) seq_count = seq_count - 1'b1;
               if (seq_count == 0) parse_phase = PH_QUALNL;
            end
            default: begin
               // Quality newline: skipped whatever its value.
               parse_phase = PH_START;
               seq_count   = '0;
            end
         endcase
         if (err == ERR_NONE && last && parse_phase != PH_START) err = ERR_TRUNC;
         if (err != ERR_NONE) begin
            err_latch = err;
            raised    = 1'b1;
         end
      end
      if (emit || raised || last) begin
         beat.out_byte   = emit ? b : 8'h00;
         beat.has_byte   = emit;
         beat.error_code = err_latch;
         beat.stream_end = last;
         expected_beats.push_back(beat);
      end
      // End of file puts everything back to the reset state.
      if (last) begin
         parse_phase = PH_START;
         seq_count   = '0;
         err_latch   = ERR_NONE;
      end
   endfunction

   // ------------------------------------------------------------------
   // File construction
   // ------------------------------------------------------------------
   function automatic logic [7:0] any_but(input logic [7:0] avoid);
      logic [7:0] v;
      do v = 8'($urandom_range(255)); while (v == avoid);
      return v;
   endfunction

   function automatic void put(input logic [7:0] b);
      file_buf.push_back(b);
   endfunction

   // Move the file under construction to the driver, marking its last byte.
   function automatic void flush_file();
      file_byte_type fb;
      for (int i = 0; i < file_buf.size(); i++) begin
         fb.data = file_buf[i];
         fb.last = (i == file_buf.size() - 1);
         pending_bytes.push_back(fb);
      end
      items_queued += file_buf.size();
      file_buf.delete();
   endfunction

   // Append one four-line record; header and sequence bytes never hold a
   // newline, quality bytes may hold anything.
   function automatic void add_record(input int seq_len, input flaw_type flaw);
      int hdr_len;
      int rec_len;
      int cut;
      hdr_len = $urandom_range(8);
      rec_len = hdr_len + 2 * seq_len + 6;
      put((flaw == FLAW_NO_AT) ? any_but(CHAR_AT) : CHAR_AT);
      repeat (hdr_len) put(any_but(CHAR_NL));
      put(CHAR_NL);
      repeat (seq_len) put(any_but(CHAR_NL));
      put(CHAR_NL);
      put((flaw == FLAW_PLUS_CHAR) ? any_but(CHAR_PLUS) : CHAR_PLUS);
      put((flaw == FLAW_PLUS_NL) ? any_but(CHAR_NL) : CHAR_NL);
      repeat (seq_len) put(8'($urandom_range(255)));
      put(($urandom_range(7) == 0) ? 8'($urandom_range(255)) : CHAR_NL);
      if (flaw == FLAW_CUT) begin
         cut = $urandom_range(rec_len - 1, 1);
         repeat (cut) void'(file_buf.pop_back());
      end
   endfunction

   // Mostly clean files of one to five records with random content, some damaged,
   // a few with stray bytes at the end.
   function automatic void random_file();
      int       n_rec;
      int       r;
      int       seq_len;
      flaw_type flaw;
      n_rec = $urandom_range(5, 1);
      for (int i = 0; i < n_rec; i++) begin
         r = $urandom_range(99);
         if (r < 80) flaw = FLAW_NONE;
         else if (r < 84) flaw = FLAW_NO_AT;
         else if (r < 88) flaw = FLAW_PLUS_CHAR;
         else if (r < 92) flaw = FLAW_PLUS_NL;
         else flaw = FLAW_CUT;
         seq_len = ($urandom_range(9) == 0) ? $urandom_range(200) : $urandom_range(24);
         add_record(seq_len, flaw);
         if (flaw == FLAW_CUT) break;
      end
      if ($urandom_range(15) == 0) repeat ($urandom_range(4, 1)) put(8'($urandom_range(255)));
      flush_file();
   endfunction

   // Hold the sender back until every queued byte is in and every result out.
   task automatic wait_drained();
      while (items_taken != items_queued || expected_beats.size() != 0) @(negedge clock);
   endtask

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("%s", msg);
   endfunction

   // ------------------------------------------------------------------
   // Driver: inputs change on the falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         rsp_tready <= 1'b0;
      end else begin
         // A new byte goes out only once the previous transaction completed.
         if (!req_tvalid || req_taken) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               drive_item = pending_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= drive_item.data;
               req_tlast  <= drive_item.last;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken = 1'b0;
      end else if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_beats.size());
         $display("Regression FAIL");
         $finish;
      end else begin
         cycle_count++;
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            items_taken++;
            advance_parser(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               note_failure($sformatf("unexpected result: byte %h has %0d err %0d end %0d",
                  rsp_tdata[7:0], rsp_tuser, rsp_tdata[10:8], rsp_tlast));
            end else begin
               want = expected_beats.pop_front();
               if (rsp_tdata[7:0] !== want.out_byte || rsp_tuser !== want.has_byte ||
                   rsp_tdata[10:8] !== want.error_code || rsp_tlast !== want.stream_end)
                  note_failure($sformatf(
                     "mismatch: want byte %h has %0d err %0d end %0d, got %h %0d %0d %0d",
                     want.out_byte, want.has_byte, want.error_code, want.stream_end,
                     rsp_tdata[7:0], rsp_tuser, rsp_tdata[10:8], rsp_tlast));
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed files, sent with no idling on either side.
      // Extreme byte values everywhere; '\n' inside the quality line.
      put("@"); put("r"); put(8'hFF); put(8'h00); put(CHAR_NL);
      put(8'h00); put(8'hFF); put(CHAR_AT); put(CHAR_PLUS); put("A"); put(CHAR_NL);
      put(CHAR_PLUS); put(CHAR_NL);
      put(CHAR_NL); put(8'h00); put(8'hFF); put(CHAR_AT); put("!"); put(CHAR_NL);
      flush_file();
      // Empty read; the quality newline can be any byte.
      add_record(0, FLAW_NONE);
      flush_file();
      put(CHAR_AT); put(CHAR_NL); put(CHAR_NL); put(CHAR_PLUS); put(CHAR_NL); put("X");
      flush_file();
      // Each malformed record, with bytes after the error to be swallowed.
      add_record(3, FLAW_NO_AT);
      flush_file();
      add_record(3, FLAW_PLUS_CHAR);
      flush_file();
      add_record(3, FLAW_PLUS_NL);
      flush_file();
      // File cut in the read: copied byte, truncation and end in one result.
      put(CHAR_AT); put("h"); put(CHAR_NL); put("A"); put("C");
      flush_file();
      // One-byte files: truncation and missing '@' on the final byte.
      put(CHAR_AT);
      flush_file();
      put("Z");
      flush_file();
      // Two clean records, then one cut short.
      add_record(2, FLAW_NONE);
      add_record(5, FLAW_NONE);
      add_record(4, FLAW_CUT);
      flush_file();
      wait_drained();

      // Random files under each idling pattern; the sender drains fully
      // between patterns.
      for (int ph = 0; ph < 4; ph++) begin
         int start;
         start = items_queued;
         @(posedge clock);
         case (ph)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 62; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 62; end
            default: begin sender_idle_pct = 29; rsp_stall_pct = 29; end
         endcase
         while (items_queued - start < BYTES_PER_PHASE) random_file();
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
